### sv/s2tw_pkg.sv
// shared types, codes and helper functions for the stage-2 table walker
package s2tw_pkg;

    localparam int PaBits = 40;

    localparam int CfgIndexWidth = 3;
    localparam int CfgDataWidth  = 48;

    typedef enum logic [CfgIndexWidth-1:0] {
        REG_REGION_SIZE_OFFSET = 3'd0,
        REG_GRANULE_CODE       = 3'd1,
        REG_OUTPUT_SIZE_CODE   = 3'd2,
        REG_START_LEVEL_CODE   = 3'd3,
        REG_TABLE_BASE         = 3'd4,
        REG_BIG_ENDIAN_TABLES  = 3'd5,
        REG_GUEST_IS_AARCH32   = 3'd6
    } cfg_reg_t;

    typedef enum logic [2:0] {
        KIND_READ     = 3'd0,
        KIND_XLATE    = 3'd1,
        KIND_FAULT    = 3'd2,
        KIND_BAD_CFG  = 3'd3,
        KIND_READ_ERR = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        FAULT_NONE        = 2'd0,
        FAULT_TRANSLATION = 2'd1,
        FAULT_ADDR_SIZE   = 2'd2,
        FAULT_ACCESS      = 2'd3
    } fault_t;

    typedef enum logic {
        CMD_START    = 1'b0,
        CMD_RESPONSE = 1'b1
    } cmd_t;

    typedef struct packed {
        logic [5:0]  region_size_offset;
        logic [1:0]  granule_code;
        logic [2:0]  output_size_code;
        logic [1:0]  start_level_code;
        logic [47:0] table_base;
        logic        big_endian_tables;
        logic        guest_is_aarch32;
    } cfg_t;

    typedef struct packed {
        logic        read_failed;
        logic [63:0] descriptor;
        logic [47:0] ipa;
        cmd_t        cmd;
    } item_t;

    typedef struct packed {
        logic        busy;
        logic [1:0]  level;
        logic [47:0] base;
        logic [5:0]  top;
        logic [47:0] pipa;
    } walk_state_t;

    typedef struct packed {
        kind_t       kind;
        logic [47:0] read_address;
        logic [47:0] output_address;
        logic [5:0]  block_size_log2;
        logic [1:0]  walk_level;
        logic        can_read;
        logic        can_write;
        logic [11:0] upper_attributes;
        fault_t      fault_code;
    } result_t;

    // bits lo..hi set, clear where lo lies above hi
    function automatic logic [47:0] bits_mask(input logic [5:0] hi, input logic [5:0] lo);
        logic [47:0] m;
        for (int i = 0; i < 48; i++) begin
            m[i] = (6'(i) >= lo) && (6'(i) <= hi);
        end
        return m;
    endfunction

    function automatic logic [5:0] page_shift(input logic [1:0] gran);
        logic [5:0] ps;
        case (gran)
            2'd0:    ps = 6'd12;
            2'd1:    ps = 6'd14;
            default: ps = 6'd16;
        endcase
        return ps;
    endfunction

    // lowest input address bit resolved at a level
    function automatic logic [5:0] level_bottom(input logic [1:0] gran, input logic [1:0] lvl);
        logic [5:0] ps;
        logic [3:0] stride;
        logic [1:0] steps;
        ps     = page_shift(gran);
        stride = 4'(ps - 6'd3);
        steps  = 2'd3 - lvl;
        return 6'(steps * stride) + ps;
    endfunction

    function automatic logic out_too_wide(input logic [2:0] osc, input logic [47:0] v);
        logic [5:0] os;
        case (osc)
            3'd0:    os = 6'd32;
            3'd1:    os = 6'd36;
            3'd2:    os = 6'd40;
            3'd3:    os = 6'd42;
            3'd4:    os = 6'd44;
            default: os = 6'd48;
        endcase
        if (os > 6'(PaBits)) begin
            os = 6'(PaBits);
        end
        return (os != 6'd48) && (|(v & bits_mask(6'd47, os)));
    endfunction

    function automatic logic [63:0] byte_swap(input logic [63:0] v);
        logic [63:0] r;
        for (int b = 0; b < 8; b++) begin
            r[8*b +: 8] = v[8*(7-b) +: 8];
        end
        return r;
    endfunction

endpackage

### sv/s2tw_cfg.sv
// configuration register file of the stage-2 table walker
module s2tw_cfg
    import s2tw_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgDataWidth-1:0]  cfg_data,
    output cfg_t                     cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.region_size_offset <= 6'd24;
            cfg_reg.granule_code       <= 2'd0;
            cfg_reg.output_size_code   <= 3'd2;
            cfg_reg.start_level_code   <= 2'd1;
            cfg_reg.table_base         <= '0;
            cfg_reg.big_endian_tables  <= 1'b0;
            cfg_reg.guest_is_aarch32   <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_REGION_SIZE_OFFSET: cfg_reg.region_size_offset <= cfg_data[5:0];
                REG_GRANULE_CODE:       cfg_reg.granule_code       <= cfg_data[1:0];
                REG_OUTPUT_SIZE_CODE:   cfg_reg.output_size_code   <= cfg_data[2:0];
                REG_START_LEVEL_CODE:   cfg_reg.start_level_code   <= cfg_data[1:0];
                REG_TABLE_BASE:         cfg_reg.table_base         <= cfg_data[47:0];
                REG_BIG_ENDIAN_TABLES:  cfg_reg.big_endian_tables  <= cfg_data[0];
                REG_GUEST_IS_AARCH32:   cfg_reg.guest_is_aarch32   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### sv/s2tw_step.sv
// one walk step: start check or descriptor decode, next walk state and result
module s2tw_step
    import s2tw_pkg::*;
(
    input  cfg_t        cfg,
    input  walk_state_t st,
    input  item_t       item,
    output walk_state_t nxt,
    output result_t     res
);

    logic [5:0]        ps_w;
    logic [5:0]        stride_w;
    logic signed [2:0] start_lvl;
    logic [6:0]        insz;
    logic              cfg_bad;
    logic [5:0]        bot_start;
    logic signed [7:0] first_span;
    logic signed [7:0] size_lim;
    logic [5:0]        base_lo;
    logic [5:0]        bot_cur;
    logic [5:0]        bot_rd;
    logic [1:0]        first_block;
    logic [63:0]       desc;
    logic [47:0]       idx;
    logic              do_read;

    always_comb begin
        res      = '0;
        nxt      = st;
        do_read  = 1'b0;
        idx      = '0;
        bot_rd   = '0;

        ps_w      = page_shift(cfg.granule_code);
        stride_w  = ps_w - 6'd3;
        start_lvl = ((cfg.granule_code == 2'd0) ? 3'sd2 : 3'sd3)
                    - $signed({1'b0, cfg.start_level_code});
        insz      = 7'd64 - {1'b0, cfg.region_size_offset};
        bot_start = level_bottom(cfg.granule_code, start_lvl[1:0]);
        first_span = $signed({1'b0, insz}) - $signed({2'b00, bot_start});
        size_lim   = $signed({2'b00, stride_w}) + 8'sd4;
        base_lo    = 6'(first_span + 8'sd3);

        cfg_bad = (insz > 7'd48) || (insz < 7'd25);
        case (cfg.granule_code)
            2'd0: begin
                if (start_lvl < 3'sd0 || (start_lvl == 3'sd0 && PaBits <= 42)) begin
                    cfg_bad = 1'b1;
                end
            end
            2'd1: begin
                if (start_lvl == 3'sd0 || (start_lvl == 3'sd1 && PaBits <= 40)) begin
                    cfg_bad = 1'b1;
                end
            end
            default: begin
                if (start_lvl == 3'sd0 || (start_lvl == 3'sd1 && PaBits <= 42)) begin
                    cfg_bad = 1'b1;
                end
            end
        endcase
        if (insz > 7'(PaBits) && (!cfg.guest_is_aarch32 || insz > 7'd40)) begin
            cfg_bad = 1'b1;
        end
        if (first_span < 8'sd1 || first_span > size_lim) begin
            cfg_bad = 1'b1;
        end

        bot_cur     = level_bottom(cfg.granule_code, st.level);
        first_block = (cfg.granule_code == 2'd0) ? 2'd1 : 2'd2;
        desc        = cfg.big_endian_tables ? byte_swap(item.descriptor) : item.descriptor;

        if (item.cmd == CMD_START) begin
            nxt.busy = 1'b0;
            if (cfg_bad) begin
                res.kind = KIND_BAD_CFG;
            end else if (out_too_wide(cfg.output_size_code, cfg.table_base)) begin
                res.kind       = KIND_FAULT;
                res.walk_level = start_lvl[1:0];
                res.fault_code = FAULT_ADDR_SIZE;
            end else begin
                nxt.level = start_lvl[1:0];
                nxt.base  = cfg.table_base & bits_mask(6'd47, base_lo);
                nxt.top   = 6'(insz - 7'd1);
                nxt.pipa  = item.ipa;
                do_read   = 1'b1;
            end
        end else if (!st.busy) begin
            res.kind = KIND_READ_ERR;
        end else if (item.read_failed) begin
            nxt.busy = 1'b0;
            res.kind = KIND_READ_ERR;
        end else if (!desc[0] || (desc[1:0] == 2'b01 && st.level == 2'd3)) begin
            nxt.busy       = 1'b0;
            res.kind       = KIND_FAULT;
            res.walk_level = st.level;
            res.fault_code = FAULT_TRANSLATION;
        end else if (desc[1:0] == 2'b11 && st.level != 2'd3) begin
            // table descriptor: descend one level
            if (out_too_wide(cfg.output_size_code, desc[47:0])) begin
                nxt.busy       = 1'b0;
                res.kind       = KIND_FAULT;
                res.walk_level = st.level;
                res.fault_code = FAULT_ADDR_SIZE;
            end else begin
                nxt.base  = desc[47:0] & bits_mask(6'd47, ps_w);
                nxt.level = st.level + 2'd1;
                nxt.top   = bot_cur - 6'd1;
                do_read   = 1'b1;
            end
        end else begin
            nxt.busy       = 1'b0;
            res.walk_level = st.level;
            res.kind       = KIND_FAULT;
            if (st.level < first_block) begin
                res.fault_code = FAULT_TRANSLATION;
            end else if (out_too_wide(cfg.output_size_code, desc[47:0])) begin
                res.fault_code = FAULT_ADDR_SIZE;
            end else if (!desc[10]) begin
                res.fault_code = FAULT_ACCESS;
            end else begin
                res.kind             = KIND_XLATE;
                res.output_address   = (desc[47:0] & bits_mask(6'd47, bot_cur))
                                       | (st.pipa & ~bits_mask(6'd63, bot_cur));
                res.block_size_log2  = bot_cur;
                res.can_read         = desc[6];
                res.can_write        = desc[7];
                res.upper_attributes = desc[63:52];
            end
        end

        if (do_read) begin
            bot_rd           = level_bottom(cfg.granule_code, nxt.level);
            idx              = (nxt.pipa & bits_mask(nxt.top, bot_rd)) >> (bot_rd - 6'd3);
            nxt.busy         = 1'b1;
            res.kind         = KIND_READ;
            res.read_address = nxt.base | idx;
            res.walk_level   = nxt.level;
        end
    end

endmodule

### sv/stage2_table_walker.sv
// top level of the stage-2 table walker: input register, walk step, result register
//
//  channel   direction  transaction
//  s_*       in         start request or descriptor response
//  m_*       out        read request, translation, fault or error
//  cfg_*     in         register write, one per cycle, no read-back
//
// each transaction gives one result, held first in the input register and then in the result register
// one transaction per cycle is sustained while results are taken; the walk step is one pass of logic
// between the input register and the result register, and walk state is
// updated as the result is loaded
// a stalled result holds the input register, and s_tready falls once it fills
// reset is synchronous: walker idle, configuration registers back to their defaults
module stage2_table_walker
    import s2tw_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [111:0]             s_tdata,   // ipa, descriptor
    input  logic [1:0]               s_tuser,   // cmd, read_failed
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [119:0]             m_tdata,   // read_address, output_address,
                                                // block_size_log2, walk_level, can_read,
                                                // can_write, upper_attributes, fault_code
    output logic [2:0]               m_tuser,   // kind
    input  logic                     cfg_we,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgDataWidth-1:0]  cfg_data
);

    cfg_t        cfg;
    item_t       item_reg;
    logic        in_valid_reg;
    result_t     out_reg;
    logic        out_valid_reg;
    walk_state_t state_reg;
    walk_state_t state_next;
    result_t     res_next;
    logic        advance;

    s2tw_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    s2tw_step u_step (
        .cfg  (cfg),
        .st   (state_reg),
        .item (item_reg),
        .nxt  (state_next),
        .res  (res_next)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg.cmd         <= cmd_t'(s_tuser[0]);
            item_reg.read_failed <= s_tuser[1];
            item_reg.ipa         <= s_tdata[47:0];
            item_reg.descriptor  <= s_tdata[111:48];
        end
        if (advance) begin
            out_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {out_reg.fault_code, out_reg.upper_attributes, out_reg.can_write,
                       out_reg.can_read, out_reg.walk_level, out_reg.block_size_log2,
                       out_reg.output_address, out_reg.read_address};

    // a pending read request always belongs to a live walk
    a_read_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.kind == KIND_READ) |-> state_reg.busy)
        else $error("read request shown while walker idle");

    // fault code is set for faults and only for faults
    a_fault_code: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> ((out_reg.fault_code != FAULT_NONE) == (out_reg.kind == KIND_FAULT)))
        else $error("fault code does not match result kind");

    // a finished translation maps at least one smallest page
    a_block_size: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.kind == KIND_XLATE) |-> (out_reg.block_size_log2 >= 6'd12))
        else $error("translation with block size below 4K");

    // input side only backs off while a transaction is held
    a_ready_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a held transaction");

    // walk state only moves when a transaction passes the step logic
    a_state_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(state_reg))
        else $error("walk state changed without a transaction");

endmodule

### sim/tb_stage2_table_walker.sv
// self-checking testbench for the stage-2 table walker: directed walks, limits, random walks
`timescale 1ns / 1ps

module tb_stage2_table_walker;
    import s2tw_pkg::*;

    localparam int WatchdogLimit = 5000;
    localparam int RandomPhases  = 10;

    localparam cfg_t RESET_CFG = '{
        region_size_offset: 6'd24,
        granule_code:       2'd0,
        output_size_code:   3'd2,
        start_level_code:   2'd1,
        table_base:         48'd0,
        big_endian_tables:  1'b0,
        guest_is_aarch32:   1'b0
    };

    typedef enum int {
        READY_ALWAYS,
        READY_MOSTLY,
        READY_PERIODIC,
        READY_RARELY
    } ready_mode_t;

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [111:0]             s_tdata   = '0;   // ipa, descriptor
    logic [1:0]               s_tuser   = '0;   // cmd, read_failed
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [119:0]             m_tdata;          // read_address, output_address,
                                                // block_size_log2, walk_level, can_read,
                                                // can_write, upper_attributes, fault_code
    logic [2:0]               m_tuser;          // kind
    logic                     cfg_we    = 1'b0;
    logic [CfgIndexWidth-1:0] cfg_index = '0;
    logic [CfgDataWidth-1:0]  cfg_data  = '0;

    stage2_table_walker i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // walker model: configuration copy and walk state
    cfg_t        walk_cfg    = RESET_CFG;
    logic        walk_active = 1'b0;
    logic [1:0]  walk_lvl    = '0;
    logic [47:0] walk_base   = '0;
    logic [5:0]  walk_top    = '0;
    logic [47:0] walk_ipa    = '0;

    result_t expected_results[$];
    int      burst_left   = 0;
    int      items_sent   = 0;
    int      mismatches   = 0;
    int      kind_count[5] = '{default: 0};
    int      idle_cycles  = 0;
    int          ready_cycle = 0;
    ready_mode_t ready_mode  = READY_ALWAYS;

    function automatic logic [63:0] span_mask(input int hi, input int lo);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 64; i++) begin
            if (i >= lo && i <= hi) begin
                m[i] = 1'b1;
            end
        end
        return m;
    endfunction

    function automatic int granule_shift();
        if (walk_cfg.granule_code == 2'd0) begin
            return 12;
        end else if (walk_cfg.granule_code == 2'd1) begin
            return 14;
        end
        return 16;
    endfunction

    // output address width, capped by the machine's physical address size
    function automatic int out_bits(input logic [2:0] osc);
        int os;
        case (osc)
            3'd0:    os = 32;
            3'd1:    os = 36;
            3'd2:    os = 40;
            3'd3:    os = 42;
            3'd4:    os = 44;
            default: os = 48;
        endcase
        return (os > PaBits) ? PaBits : os;
    endfunction

    function automatic bit exceeds_out_size(input logic [63:0] v);
        int os;
        os = out_bits(walk_cfg.output_size_code);
        return os != 48 && (v & span_mask(47, os)) != 0;
    endfunction

    function automatic logic [63:0] swap_bytes(input logic [63:0] v);
        logic [63:0] r;
        r = '0;
        for (int b = 0; b < 8; b++) begin
            r = {r[55:0], v[8*b +: 8]};
        end
        return r;
    endfunction

    function automatic result_t make_result(input kind_t kind, input logic [47:0] ra,
                                            input logic [47:0] oa, input int bs, input int lvl,
                                            input logic [63:0] d, input bit leaf,
                                            input fault_t fc);
        result_t r;
        r.kind             = kind;
        r.read_address     = ra;
        r.output_address   = oa;
        r.block_size_log2  = 6'(bs);
        r.walk_level       = 2'(lvl);
        r.can_read         = leaf ? d[6] : 1'b0;
        r.can_write        = leaf ? d[7] : 1'b0;
        r.upper_attributes = leaf ? d[63:52] : 12'd0;
        r.fault_code       = fc;
        return r;
    endfunction

    function automatic result_t next_read();
        int ps;
        int stride;
        int lvl;
        int bottom;
        logic [63:0] idx;
        ps     = granule_shift();
        stride = ps - 3;
        lvl    = walk_lvl;
        bottom = (3 - lvl) * stride + ps;
        idx    = ({16'd0, walk_ipa} & span_mask(walk_top, bottom)) >> (bottom - 3);
        walk_active = 1'b1;
        return make_result(KIND_READ, walk_base | idx[47:0], '0, 0, lvl, '0, 1'b0, FAULT_NONE);
    endfunction

    function automatic result_t start_walk(input logic [47:0] ipa);
        int ps;
        int stride;
        int lvl;
        int insz;
        int first_size;
        bit bad;
        ps         = granule_shift();
        stride     = ps - 3;
        lvl        = ((walk_cfg.granule_code == 2'd0) ? 2 : 3) - int'(walk_cfg.start_level_code);
        insz       = 64 - int'(walk_cfg.region_size_offset);
        first_size = insz - ((3 - lvl) * stride + ps);
        walk_active = 1'b0;
        bad = insz > 48 || insz < 25
            || (ps == 16 && (lvl == 0 || (lvl == 1 && PaBits <= 42)))
            || (ps == 14 && (lvl == 0 || (lvl == 1 && PaBits <= 40)))
            || (ps == 12 && (lvl < 0 || (lvl == 0 && PaBits <= 42)))
            || (insz > PaBits && (!walk_cfg.guest_is_aarch32 || insz > 40))
            || first_size < 1 || first_size > stride + 4;
        if (bad) begin
            return make_result(KIND_BAD_CFG, '0, '0, 0, 0, '0, 1'b0, FAULT_NONE);
        end
        if (exceeds_out_size({16'd0, walk_cfg.table_base})) begin
            return make_result(KIND_FAULT, '0, '0, 0, lvl, '0, 1'b0, FAULT_ADDR_SIZE);
        end
        walk_lvl  = 2'(lvl);
        walk_base = 48'({16'd0, walk_cfg.table_base} & span_mask(47, 3 + first_size));
        walk_top  = 6'(insz - 1);
        walk_ipa  = ipa;
        return next_read();
    endfunction

    function automatic result_t take_descriptor(input item_t it);
        logic [63:0] d;
        logic [63:0] oa;
        int ps;
        int stride;
        int lvl;
        int bottom;
        int first_block;
        if (!walk_active) begin
            return make_result(KIND_READ_ERR, '0, '0, 0, 0, '0, 1'b0, FAULT_NONE);
        end
        if (it.read_failed) begin
            walk_active = 1'b0;
            return make_result(KIND_READ_ERR, '0, '0, 0, 0, '0, 1'b0, FAULT_NONE);
        end
        d           = walk_cfg.big_endian_tables ? swap_bytes(it.descriptor) : it.descriptor;
        ps          = granule_shift();
        stride      = ps - 3;
        lvl         = walk_lvl;
        bottom      = (3 - lvl) * stride + ps;
        first_block = (walk_cfg.granule_code == 2'd0) ? 1 : 2;

        // invalid entry, or the reserved encoding at the last level
        if (!d[0] || (d[1:0] == 2'b01 && lvl == 3)) begin
            walk_active = 1'b0;
            return make_result(KIND_FAULT, '0, '0, 0, lvl, '0, 1'b0, FAULT_TRANSLATION);
        end
        if (d[1:0] == 2'b11 && lvl != 3) begin
            if (exceeds_out_size(d)) begin
                walk_active = 1'b0;
                return make_result(KIND_FAULT, '0, '0, 0, lvl, '0, 1'b0, FAULT_ADDR_SIZE);
            end
            walk_base = 48'(d & span_mask(47, ps));
            walk_lvl  = 2'(lvl + 1);
            walk_top  = 6'(bottom - 1);
            return next_read();
        end
        walk_active = 1'b0;
        if (lvl < first_block) begin
            return make_result(KIND_FAULT, '0, '0, 0, lvl, '0, 1'b0, FAULT_TRANSLATION);
        end
        if (exceeds_out_size(d)) begin
            return make_result(KIND_FAULT, '0, '0, 0, lvl, '0, 1'b0, FAULT_ADDR_SIZE);
        end
        if (!d[10]) begin
            return make_result(KIND_FAULT, '0, '0, 0, lvl, '0, 1'b0, FAULT_ACCESS);
        end
        oa = (d & span_mask(47, bottom)) | ({16'd0, walk_ipa} & ~span_mask(63, bottom));
        return make_result(KIND_XLATE, '0, oa[47:0], bottom, lvl, d, 1'b1, FAULT_NONE);
    endfunction

    function automatic result_t predict_walk_step(input item_t it);
        if (it.cmd == CMD_START) begin
            return start_walk(it.ipa);
        end
        return take_descriptor(it);
    endfunction

    function automatic logic [47:0] rand48();
        return 48'({$urandom(), $urandom()});
    endfunction

    function automatic item_t start_item(input logic [47:0] ipa);
        item_t it;
        it.cmd         = CMD_START;
        it.ipa         = ipa;
        it.descriptor  = {$urandom(), $urandom()};
        it.read_failed = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // descriptors are given as the walker sees them and stored in table byte order
    function automatic item_t response_item(input logic [63:0] d, input logic failed);
        item_t it;
        it.cmd         = CMD_RESPONSE;
        it.ipa         = rand48();
        it.descriptor  = walk_cfg.big_endian_tables ? swap_bytes(d) : d;
        it.read_failed = failed;
        return it;
    endfunction

    // mostly well-formed walks that follow the modelled state, with some noise
    function automatic item_t pick_walk_item();
        item_t it;
        int roll;
        int lvl;
        int first_block;
        logic [63:0] d;
        roll = $urandom_range(0, 99);
        if (!walk_active) begin
            if (roll < 88) begin
                return start_item(rand48());
            end
            return response_item({$urandom(), $urandom()}, 1'($urandom_range(0, 1)));
        end
        if (roll < 5) begin
            return start_item(rand48());
        end
        if (roll < 15) begin
            it = response_item({$urandom(), $urandom()}, 1'($urandom_range(0, 1)));
            return it;
        end
        lvl         = walk_lvl;
        first_block = (walk_cfg.granule_code == 2'd0) ? 1 : 2;
        d           = {$urandom(), $urandom()};
        if (lvl < 3 && (lvl < first_block || $urandom_range(0, 2) != 0)) begin
            d[1:0] = 2'b11;
        end else begin
            d[1:0] = (lvl == 3) ? 2'b11 : 2'b01;
            if ($urandom_range(0, 9) != 0) begin
                d[10] = 1'b1;
            end
        end
        if ($urandom_range(0, 9) != 0) begin
            d = d & ~span_mask(47, out_bits(walk_cfg.output_size_code));
        end
        return response_item(d, 1'b0);
    endfunction

    // input sizes that give a legal starting table for each granule and start level, or one pick in eight fully random
    function automatic cfg_t pick_config();
        cfg_t c;
        int lo;
        int hi;
        if ($urandom_range(0, 7) == 0) begin
            c = cfg_t'(63'({$urandom(), $urandom()}));
            return c;
        end
        c.granule_code     = 2'($urandom_range(0, 3));
        c.start_level_code = 2'($urandom_range(0, 1));
        if (c.granule_code == 2'd0) begin
            lo = c.start_level_code[0] ? 31 : 25;
            hi = c.start_level_code[0] ? 40 : 34;
        end else if (c.granule_code == 2'd1) begin
            lo = c.start_level_code[0] ? 26 : 25;
            hi = c.start_level_code[0] ? 40 : 29;
        end else begin
            lo = c.start_level_code[0] ? 30 : 25;
            hi = c.start_level_code[0] ? 40 : 33;
        end
        c.region_size_offset = 6'(64 - $urandom_range(hi, lo));
        c.output_size_code   = 3'($urandom_range(0, 7));
        c.table_base         = rand48();
        if ($urandom_range(0, 3) != 0) begin
            c.table_base = 48'({16'd0, c.table_base} & ~span_mask(47, out_bits(c.output_size_code)));
        end
        c.big_endian_tables = 1'($urandom_range(0, 1));
        c.guest_is_aarch32  = 1'($urandom_range(0, 1));
        return c;
    endfunction

    function automatic string result_text(input result_t r);
        return $sformatf("kind %0d ra %h oa %h size %0d lvl %0d r %b w %b ua %h fault %0d",
                         r.kind, r.read_address, r.output_address, r.block_size_log2,
                         r.walk_level, r.can_read, r.can_write, r.upper_attributes, r.fault_code);
    endfunction

    function automatic string diff_fields(input result_t a, input result_t b);
        string s;
        s = "";
        if (a.kind !== b.kind)                         s = {s, " kind"};
        if (a.read_address !== b.read_address)         s = {s, " read_address"};
        if (a.output_address !== b.output_address)     s = {s, " output_address"};
        if (a.block_size_log2 !== b.block_size_log2)   s = {s, " block_size_log2"};
        if (a.walk_level !== b.walk_level)             s = {s, " walk_level"};
        if (a.can_read !== b.can_read)                 s = {s, " can_read"};
        if (a.can_write !== b.can_write)               s = {s, " can_write"};
        if (a.upper_attributes !== b.upper_attributes) s = {s, " upper_attributes"};
        if (a.fault_code !== b.fault_code)             s = {s, " fault_code"};
        return s;
    endfunction

    task automatic send_item(input item_t it);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {it.descriptor, it.ipa};
        s_tuser  <= {it.read_failed, it.cmd};
        do @(posedge aclk); while (!s_tready);
        expected_results.push_back(predict_walk_step(it));
        burst_left--;
        items_sent++;
    endtask

    // hold off the sender until every outstanding result has been taken
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        burst_left = 0;
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [47:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
    endtask

    task automatic set_config(input cfg_t c);
        wait_for_results();
        write_reg(REG_REGION_SIZE_OFFSET, 48'(c.region_size_offset));
        write_reg(REG_GRANULE_CODE,       48'(c.granule_code));
        write_reg(REG_OUTPUT_SIZE_CODE,   48'(c.output_size_code));
        write_reg(REG_START_LEVEL_CODE,   48'(c.start_level_code));
        write_reg(REG_TABLE_BASE,         c.table_base);
        write_reg(REG_BIG_ENDIAN_TABLES,  48'(c.big_endian_tables));
        write_reg(REG_GUEST_IS_AARCH32,   48'(c.guest_is_aarch32));
        cfg_we   <= 1'b0;
        walk_cfg  = c;
    endtask

    task automatic test_idle_and_errors();
        send_item(response_item(64'h0000_0000_0000_0403, 1'b0));   // nothing to answer
        send_item(start_item(rand48()));
        send_item(response_item(64'h0000_0000_0000_0403, 1'b1));   // failed fetch
        send_item(start_item(48'd0));
        send_item(response_item(64'd0, 1'b0));                     // invalid entry
    endtask

    task automatic test_full_walk();
        send_item(start_item('1));
        send_item(response_item(64'h0000_00AB_CDEF_F003, 1'b0));
        send_item(response_item(64'h0000_0012_3456_7003, 1'b0));
        send_item(response_item(64'hFFF0_00FF_FFFF_F4C3, 1'b0));
    endtask

    task automatic test_leaf_faults();
        send_item(start_item(48'd0));
        send_item(response_item(64'h0000_0000_4000_0001, 1'b0));  // block without access flag
        send_item(start_item(rand48()));
        send_item(response_item(64'h0000_0000_4000_0441, 1'b0));  // level 1 block
        send_item(start_item(rand48()));
        send_item(response_item(64'h0000_0100_0000_0003, 1'b0));  // table above 40 bits
        send_item(start_item(rand48()));
        send_item(start_item('1));                                 // restart mid-walk
        send_item(response_item(64'h0000_0000_1000_0003, 1'b0));
        send_item(response_item(64'h0000_0000_2000_0003, 1'b0));
        send_item(response_item(64'hFFFF_FFFF_FFFF_FFFD, 1'b0));  // reserved at last level
    endtask

    task automatic test_config_limits();
        cfg_t c;
        c = RESET_CFG;
        c.region_size_offset = 6'd63;
        set_config(c);
        send_item(start_item(rand48()));
        c.region_size_offset = 6'd0;
        set_config(c);
        send_item(start_item(rand48()));
        c = RESET_CFG;
        c.region_size_offset = 6'd23;
        c.guest_is_aarch32   = 1'b1;
        set_config(c);
        send_item(start_item(rand48()));
        c = RESET_CFG;
        c.granule_code     = 2'd3;
        c.start_level_code = 2'd2;
        set_config(c);
        send_item(start_item(rand48()));
        c = RESET_CFG;
        c.table_base = '1;
        set_config(c);
        send_item(start_item(rand48()));
        // 64K granule starting at level 3 with byte-swapped tables
        c = RESET_CFG;
        c.region_size_offset = 6'd31;
        c.granule_code       = 2'd3;
        c.output_size_code   = 3'd5;
        c.start_level_code   = 2'd0;
        c.table_base         = 48'h0000_1234_0000;
        c.big_endian_tables  = 1'b1;
        set_config(c);
        send_item(start_item(rand48()));
        send_item(response_item(64'h8000_0012_3456_0743, 1'b0));
    endtask

    task automatic test_random_walks();
        cfg_t c;
        int count;
        for (int phase = 0; phase < RandomPhases; phase++) begin
            // walks still open from the previous phase carry on under the new settings
            if (phase == 3) begin
                c = '0;
            end else if (phase == 6) begin
                c = '1;
            end else begin
                c = pick_config();
            end
            set_config(c);
            count = (phase == 3 || phase == 6) ? 25 : 80;
            for (int n = 0; n < count; n++) begin
                send_item(pick_walk_item());
            end
        end
    endtask

    always @(posedge aclk) begin : check_results
        result_t got;
        result_t want;
        string   diffs;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind             = kind_t'(m_tuser);
            got.read_address     = m_tdata[47:0];
            got.output_address   = m_tdata[95:48];
            got.block_size_log2  = m_tdata[101:96];
            got.walk_level       = m_tdata[103:102];
            got.can_read         = m_tdata[104];
            got.can_write        = m_tdata[105];
            got.upper_attributes = m_tdata[117:106];
            got.fault_code       = fault_t'(m_tdata[119:118]);
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result with no transaction outstanding: %s", result_text(got));
                end
            end else begin
                want  = expected_results.pop_front();
                diffs = diff_fields(want, got);
                if (diffs != "") begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch in%s", diffs);
                        $display("  expected %s", result_text(want));
                        $display("  actual   %s", result_text(got));
                    end
                end else if (got.kind <= KIND_READ_ERR) begin
                    kind_count[int'(got.kind)]++;
                end
            end
        end

        ready_cycle++;
        if (ready_cycle % 150 == 0) begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
        end
        case (ready_mode)
            READY_ALWAYS:   m_tready <= 1'b1;
            READY_MOSTLY:   m_tready <= ($urandom_range(0, 3) != 0);
            READY_PERIODIC: m_tready <= ((ready_cycle % 5) < 2);
            default:        m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WatchdogLimit) begin
            $display("timeout: no transaction for %0d cycles", WatchdogLimit);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_idle_and_errors();
        test_full_walk();
        test_leaf_faults();
        test_config_limits();
        test_random_walks();

        wait_for_results();
        repeat (8) @(posedge aclk);

        $display("stimulus: %0d transactions over directed walks, configuration limits and %0d random setting phases",
                 items_sent, RandomPhases);
        $display("results: %0d reads, %0d translations, %0d faults, %0d bad configs, %0d read errors",
                 kind_count[0], kind_count[1], kind_count[2], kind_count[3], kind_count[4]);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatching results", mismatches);
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
